// ----- hw/rtl/panel_step_navigation_autorepeat_assert.svh -----
// Assertion macros for the panel step navigation block.
// Depends on a clock named aclk and an active-low reset named aresetn in scope.
`ifndef PANEL_STEP_NAVIGATION_AUTOREPEAT_ASSERT_SVH
`define PANEL_STEP_NAVIGATION_AUTOREPEAT_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define PSNA_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Check that a trigger is followed by a condition in the next clock cycle.
`define PSNA_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (trig) |=> (cond)) else $error(msg);

`endif

// ----- hw/rtl/psna_pkg.sv -----
// Shared constants for the panel step navigation block: register indexes,
// mode codes, field widths and reset values. No dependencies.
package psna_pkg;

    // Configuration port
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_STEP     = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_EXPANDER     = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FIRST_DELAY  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_REPEAT_DELAY = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ENTRY_DELAY  = 3'd4;

    // Field widths
    localparam int MAX_STEP_BITS = 5;
    localparam int DELAY_BITS    = 16;
    localparam int MODE_BITS     = 2;
    localparam int IN_TDATA_BITS = 8;
    localparam int STEP_BITS_DEF = 5;

    // View and edit modes
    localparam logic [MODE_BITS-1:0] MODE_VIEW1 = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_VIEW2 = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_EDIT1 = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_EDIT2 = 2'd3;

    // Register reset values
    localparam logic [MAX_STEP_BITS-1:0] MAX_STEP_RST     = 5'd31;
    localparam logic [DELAY_BITS-1:0]    FIRST_DELAY_RST  = 16'd10;
    localparam logic [DELAY_BITS-1:0]    REPEAT_DELAY_RST = 16'd4;
    localparam logic [DELAY_BITS-1:0]    ENTRY_DELAY_RST  = 16'd40;

endpackage

// ----- hw/rtl/panel_step_navigation_autorepeat.sv -----
// Panel step navigation with key auto-repeat: mode, step and section tracking.
// Depends on psna_pkg and panel_step_navigation_autorepeat_assert.svh.

// One scan word is taken per clock while the output is not stalled. Its result
// is computed in the same cycle from the word and the held state and lands in
// the output register, so it shows on the master side in the cycle after
// acceptance. The slave side is ready whenever the output register is empty
// or being drained, which sustains one word per clock while m_tready is high.
// Configuration writes are always accepted; a delay register written with
// zero counts as one tick. No clearing pass is needed after reset.

`include "panel_step_navigation_autorepeat_assert.svh"

module panel_step_navigation_autorepeat #(
    parameter int STEP_BITS = psna_pkg::STEP_BITS_DEF,
    localparam int OUT_FIELD_BITS = STEP_BITS + 7,
    localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    // Scan words. tdata from bit 0: left_pressed, right_pressed,
    // view1_pressed, view2_pressed, unit1_section, unit2_section
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [psna_pkg::IN_TDATA_BITS-1:0]    s_tdata,

    // Results. tdata from bit 0: mode_now, step_now, section_now,
    // section_cmd_valid, section_cmd_unit, section_cmd_value, refresh
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [OUT_TDATA_BITS-1:0]             m_tdata,

    // Register writes
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [psna_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [psna_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    localparam int DB = psna_pkg::DELAY_BITS;
    localparam int MB = psna_pkg::MODE_BITS;
    localparam logic [DB-1:0]        DELAY_ONE = DB'(1);
    localparam logic [STEP_BITS-1:0] STEP_ONE  = STEP_BITS'(1);

    // Configuration registers
    logic [psna_pkg::MAX_STEP_BITS-1:0] max_step_reg;
    logic                               expander_reg;
    logic [DB-1:0]                      first_delay_reg;
    logic [DB-1:0]                      repeat_delay_reg;
    logic [DB-1:0]                      entry_delay_reg;

    // Navigation state
    logic [MB-1:0]        mode_reg, mode_next;
    logic [STEP_BITS-1:0] step_reg, step_next;
    logic                 section_reg, section_next;
    logic [DB-1:0]        left_cnt_reg, left_cnt_next;
    logic [DB-1:0]        right_cnt_reg, right_cnt_next;

    // Output register
    logic                      out_valid_reg;
    logic [OUT_TDATA_BITS-1:0] out_data_reg, out_data_next;

    // Decoded scan word and intermediate values
    logic lp, rp, v1, v2, s1, s2;
    logic                 in_accept;
    logic [STEP_BITS-1:0] top;
    logic [DB-1:0]        first_nz, repeat_nz, entry_nz;
    logic [MB-1:0]        mode_a, mode_b;
    logic                 enter, cmd, cmd_unit, cmd_value;
    logic                 left_fire, right_fire, refresh;
    logic [STEP_BITS-1:0] step_a, step_b;
    logic [DB-1:0]        left_a, right_a, left_b, right_b;

    assign lp = s_tdata[0];
    assign rp = s_tdata[1];
    assign v1 = s_tdata[2];
    assign v2 = s_tdata[3];
    assign s1 = s_tdata[4];
    assign s2 = s_tdata[5];

    assign s_tready  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // Treat a zero delay as one tick
    assign first_nz  = (first_delay_reg  == '0) ? DELAY_ONE : first_delay_reg;
    assign repeat_nz = (repeat_delay_reg == '0) ? DELAY_ONE : repeat_delay_reg;
    assign entry_nz  = (entry_delay_reg  == '0) ? DELAY_ONE : entry_delay_reg;
    assign top       = STEP_BITS'(max_step_reg);

    // Work out the next state and the result for one scan word
    always_comb begin
        // view buttons, view two wins
        if (v2) begin
            mode_a = psna_pkg::MODE_VIEW2;
        end else if (v1) begin
            mode_a = psna_pkg::MODE_VIEW1;
        end else begin
            mode_a = mode_reg;
        end

        // enter edit mode on a step key in a view mode
        enter = (lp || rp) && !mode_a[1];
        unique case (mode_a)
            psna_pkg::MODE_VIEW1: mode_b = enter ? psna_pkg::MODE_EDIT1 : mode_a;
            psna_pkg::MODE_VIEW2: mode_b = enter ? psna_pkg::MODE_EDIT2 : mode_a;
            default:              mode_b = mode_a;
        endcase
        section_next = enter ? (mode_a[0] ? s2 : s1) : section_reg;
        step_a       = enter ? '0 : step_reg;
        left_a       = enter ? entry_nz : left_cnt_reg;
        right_a      = enter ? entry_nz : right_cnt_reg;

        // section change request without an expander
        cmd       = !expander_reg && (lp || rp) && (v1 || v2);
        cmd_unit  = cmd && !v1;
        cmd_value = cmd && !lp;
        if (cmd) begin
            mode_next = cmd_unit ? psna_pkg::MODE_VIEW2 : psna_pkg::MODE_VIEW1;
        end else begin
            mode_next = mode_b;
        end

        // count down held keys, reload on release
        if (!lp) begin
            left_b = first_nz;
        end else if (left_a != '0) begin
            left_b = left_a - DELAY_ONE;
        end else begin
            left_b = left_a;
        end
        if (!rp) begin
            right_b = first_nz;
        end else if (right_a != '0) begin
            right_b = right_a - DELAY_ONE;
        end else begin
            right_b = right_a;
        end

        // step left first, wrapping to the top
        left_fire = (left_b == '0);
        if (!left_fire) begin
            step_b = step_a;
        end else if (step_a == '0 || step_a > top) begin
            step_b = top;
        end else begin
            step_b = step_a - STEP_ONE;
        end
        left_cnt_next = left_fire ? repeat_nz : left_b;

        // then step right, wrapping to zero
        right_fire = (right_b == '0);
        if (!right_fire) begin
            step_next = step_b;
        end else if (step_b >= top) begin
            step_next = '0;
        end else begin
            step_next = step_b + STEP_ONE;
        end
        right_cnt_next = right_fire ? repeat_nz : right_b;

        refresh = enter || cmd || left_fire || right_fire;

        out_data_next = OUT_TDATA_BITS'({refresh, cmd_value, cmd_unit, cmd,
                                         section_next, step_next, mode_next});
    end

    // Hold configuration, ignore writes beyond the register list
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_step_reg     <= psna_pkg::MAX_STEP_RST;
            expander_reg     <= 1'b0;
            first_delay_reg  <= psna_pkg::FIRST_DELAY_RST;
            repeat_delay_reg <= psna_pkg::REPEAT_DELAY_RST;
            entry_delay_reg  <= psna_pkg::ENTRY_DELAY_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                psna_pkg::REG_MAX_STEP:
                    max_step_reg <= cfg_data[psna_pkg::MAX_STEP_BITS-1:0];
                psna_pkg::REG_EXPANDER:     expander_reg     <= cfg_data[0];
                psna_pkg::REG_FIRST_DELAY:  first_delay_reg  <= cfg_data[DB-1:0];
                psna_pkg::REG_REPEAT_DELAY: repeat_delay_reg <= cfg_data[DB-1:0];
                psna_pkg::REG_ENTRY_DELAY:  entry_delay_reg  <= cfg_data[DB-1:0];
                default: ;
            endcase
        end
    end

    // Advance the navigation state on each accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= psna_pkg::MODE_VIEW1;
            step_reg      <= '0;
            section_reg   <= 1'b0;
            left_cnt_reg  <= psna_pkg::FIRST_DELAY_RST;
            right_cnt_reg <= psna_pkg::FIRST_DELAY_RST;
        end else if (in_accept) begin
            mode_reg      <= mode_next;
            step_reg      <= step_next;
            section_reg   <= section_next;
            left_cnt_reg  <= left_cnt_next;
            right_cnt_reg <= right_cnt_next;
        end
    end

    // Load the result word, drop valid once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            out_data_reg <= out_data_next;
        end
    end

    // Counters are reloaded before they could rest at zero
    `PSNA_ASSERT_ALWAYS(a_left_cnt_nonzero, left_cnt_reg != '0, "left counter at zero")
    `PSNA_ASSERT_ALWAYS(a_right_cnt_nonzero, right_cnt_reg != '0, "right counter at zero")
    // An accepted word always produces a result word
    `PSNA_ASSERT_NEXT(a_accept_gives_result, in_accept, m_tvalid, "result word missing")
    // A section request always comes with a display refresh
    `PSNA_ASSERT_ALWAYS(a_cmd_refresh,
        !m_tvalid || !m_tdata[STEP_BITS+3] || m_tdata[STEP_BITS+6],
        "section request without refresh")

endmodule

// ----- bench/panel_step_navigation_autorepeat_tb.sv -----
// Self-checking bench for panel_step_navigation_autorepeat: drives scan words and
// register writes, predicts each result word and compares it field by field.
// Depends on psna_pkg and the block's RTL.
module panel_step_navigation_autorepeat_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import psna_pkg::*;

    localparam int STEP_W = STEP_BITS_DEF;
    localparam int OUT_TDATA_BITS = ((STEP_W + 7 + 7) / 8) * 8;

    // Scan word fields, lowest bit first from the bottom of the list
    typedef struct packed {
        logic unit2_section;
        logic unit1_section;
        logic view2_pressed;
        logic view1_pressed;
        logic right_pressed;
        logic left_pressed;
    } scan_word_t;

    // Result word fields, lowest bit first from the bottom of the list
    typedef struct packed {
        logic                 refresh;
        logic                 cmd_value;
        logic                 cmd_unit;
        logic                 cmd_valid;
        logic                 section;
        logic [STEP_W-1:0]    step;
        logic [MODE_BITS-1:0] mode;
    } nav_result_t;

    localparam int RES_BITS = $bits(nav_result_t);

    logic                        aclk      = 1'b0;
    logic                        aresetn   = 1'b0;
    logic                        s_tvalid  = 1'b0;
    logic                        s_tready;
    logic [IN_TDATA_BITS-1:0]    s_tdata   = '0;
    logic                        m_tvalid;
    logic                        m_tready  = 1'b0;
    logic [OUT_TDATA_BITS-1:0]   m_tdata;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [CFG_INDEX_BITS-1:0]   cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]    cfg_data  = '0;

    panel_step_navigation_autorepeat #(.STEP_BITS(STEP_W)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    // Register copies
    logic [MAX_STEP_BITS-1:0] step_limit     = MAX_STEP_RST;
    logic                     expander_fitted = 1'b0;
    logic [DELAY_BITS-1:0]    first_delay    = FIRST_DELAY_RST;
    logic [DELAY_BITS-1:0]    repeat_delay   = REPEAT_DELAY_RST;
    logic [DELAY_BITS-1:0]    entry_delay    = ENTRY_DELAY_RST;

    // Panel state copies
    logic [MODE_BITS-1:0]     mode_q    = MODE_VIEW1;
    logic [STEP_W-1:0]        step_q    = '0;
    logic                     section_q = 1'b0;
    logic [DELAY_BITS-1:0]    left_cnt  = FIRST_DELAY_RST;
    logic [DELAY_BITS-1:0]    right_cnt = FIRST_DELAY_RST;

    scan_word_t  pending_scans[$];
    nav_result_t expected_results[$];
    int          scans_queued = 0;
    int          scans_taken  = 0;
    int          fault_cnt    = 0;
    int          send_idle_pct = 22;
    int          recv_idle_pct = 81;
    int          stall_left   = 0;
    bit          stall_done   = 1'b0;

    function automatic logic [DELAY_BITS-1:0] at_least_one(logic [DELAY_BITS-1:0] v);
        return (v == '0) ? DELAY_BITS'(1) : v;
    endfunction

    // Advance the panel state by one scan tick and return the result word
    function automatic nav_result_t advance_panel(scan_word_t w);
        nav_result_t r;
        logic [STEP_W-1:0] top;
        r = '0;
        top = STEP_W'(step_limit);

        if (w.view1_pressed) mode_q = MODE_VIEW1;
        if (w.view2_pressed) mode_q = MODE_VIEW2;

        // enter edit from a view mode on any step key
        if ((w.left_pressed || w.right_pressed) &&
            (mode_q == MODE_VIEW1 || mode_q == MODE_VIEW2)) begin
            section_q = (mode_q == MODE_VIEW1) ? w.unit1_section : w.unit2_section;
            mode_q    = (mode_q == MODE_VIEW1) ? MODE_EDIT1 : MODE_EDIT2;
            step_q    = '0;
            left_cnt  = at_least_one(entry_delay);
            right_cnt = left_cnt;
            r.refresh = 1'b1;
        end

        // step key plus view button asks for a section change
        if (!expander_fitted && (w.left_pressed || w.right_pressed) &&
            (w.view1_pressed || w.view2_pressed)) begin
            r.cmd_valid = 1'b1;
            r.cmd_unit  = !w.view1_pressed;
            r.cmd_value = !w.left_pressed;
            mode_q      = w.view1_pressed ? MODE_VIEW1 : MODE_VIEW2;
            r.refresh   = 1'b1;
        end

        if (w.left_pressed && left_cnt != '0) left_cnt = left_cnt - 1'b1;
        else if (!w.left_pressed) left_cnt = at_least_one(first_delay);
        if (w.right_pressed && right_cnt != '0) right_cnt = right_cnt - 1'b1;
        else if (!w.right_pressed) right_cnt = at_least_one(first_delay);

        // left expires first, then right
        if (left_cnt == '0) begin
            r.refresh = 1'b1;
            if (step_q == '0 || step_q > top) step_q = top;
            else step_q = step_q - 1'b1;
            left_cnt = at_least_one(repeat_delay);
        end
        if (right_cnt == '0) begin
            r.refresh = 1'b1;
            if (step_q >= top) step_q = '0;
            else step_q = step_q + 1'b1;
            right_cnt = at_least_one(repeat_delay);
        end

        r.mode    = mode_q;
        r.step    = step_q;
        r.section = section_q;
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fault_cnt++;
        end
    endfunction

    // Offer scan words; predict each one on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                expected_results.push_back(advance_panel(scan_word_t'(s_tdata[5:0])));
                scans_taken <= scans_taken + 1;
            end
            if (pending_scans.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= IN_TDATA_BITS'(pending_scans.pop_front());
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Drain results; hold off once for a long stretch to back up the input
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (!stall_done && scans_taken >= 300) begin
            stall_done <= 1'b1;
            stall_left <= 250;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each result word with the oldest prediction
    always @(posedge aclk) begin : result_check
        nav_result_t got;
        nav_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = nav_result_t'(m_tdata[RES_BITS-1:0]);
            if (expected_results.size() == 0) begin
                $error("result word %h with no prediction waiting", m_tdata);
                fault_cnt++;
            end else begin
                want = expected_results.pop_front();
                check_field("mode_now", want.mode, got.mode);
                check_field("step_now", want.step, got.step);
                check_field("section_now", want.section, got.section);
                check_field("section_cmd_valid", want.cmd_valid, got.cmd_valid);
                check_field("section_cmd_unit", want.cmd_unit, got.cmd_unit);
                check_field("section_cmd_value", want.cmd_value, got.cmd_value);
                check_field("refresh", want.refresh, got.refresh);
            end
        end
    end

    task automatic push_scan(input bit lp, input bit rp, input bit v1, input bit v2,
                             input bit s1, input bit s2);
        scan_word_t w;
        w.left_pressed  = lp;
        w.right_pressed = rp;
        w.view1_pressed = v1;
        w.view2_pressed = v2;
        w.unit1_section = s1;
        w.unit2_section = s2;
        pending_scans.push_back(w);
        scans_queued++;
    endtask

    task automatic program_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                               input logic [CFG_DATA_BITS-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_MAX_STEP:     step_limit      = value[MAX_STEP_BITS-1:0];
            REG_EXPANDER:     expander_fitted = value[0];
            REG_FIRST_DELAY:  first_delay     = value;
            REG_REPEAT_DELAY: repeat_delay    = value;
            REG_ENTRY_DELAY:  entry_delay     = value;
            default: ;
        endcase
    endtask

    task automatic program_all(input int ms, input int ex, input int fd, input int rd,
                               input int ed);
        program_reg(REG_MAX_STEP, CFG_DATA_BITS'(ms));
        program_reg(REG_EXPANDER, CFG_DATA_BITS'(ex));
        program_reg(REG_FIRST_DELAY, CFG_DATA_BITS'(fd));
        program_reg(REG_REPEAT_DELAY, CFG_DATA_BITS'(rd));
        program_reg(REG_ENTRY_DELAY, CFG_DATA_BITS'(ed));
    endtask

    // Wait until every word went in and every result came back
    task automatic wait_drained();
        do @(posedge aclk);
        while (pending_scans.size() != 0 || s_tvalid || expected_results.size() != 0);
        repeat (3) @(posedge aclk);
    endtask

    // Mostly held keys with random sections, some view presses, some noise
    task automatic queue_key_play(input int n);
        int start;
        int kind;
        int pick;
        bit lk;
        bit rk;
        start = scans_queued;
        while (scans_queued - start < n) begin
            kind = $urandom_range(99);
            if (kind < 70) begin
                pick = $urandom_range(9);
                lk = (pick < 4) || (pick == 9);
                rk = (pick >= 4);
                if ($urandom_range(4) == 0)
                    push_scan(0, 0, $urandom_range(1), $urandom_range(1),
                              $urandom_range(1), $urandom_range(1));
                repeat ($urandom_range(1, 24))
                    push_scan(lk, rk, 0, 0, $urandom_range(1), $urandom_range(1));
                repeat ($urandom_range(1, 3))
                    push_scan(0, 0, 0, 0, $urandom_range(1), $urandom_range(1));
            end else if (kind < 85) begin
                push_scan($urandom_range(1), $urandom_range(1), $urandom_range(1),
                          $urandom_range(1), $urandom_range(1), $urandom_range(1));
                push_scan(0, 0, 0, 0, $urandom_range(1), $urandom_range(1));
            end else begin
                repeat ($urandom_range(1, 4))
                    push_scan($urandom_range(1), $urandom_range(1), $urandom_range(1),
                              $urandom_range(1), $urandom_range(1), $urandom_range(1));
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Short delays so the directed words reach stepping quickly
        program_all(31, 0, 1, 1, 2);

        push_scan(0, 0, 0, 0, 0, 0);
        push_scan(0, 0, 1, 0, 0, 0);
        push_scan(0, 0, 0, 0, 1, 1);
        push_scan(0, 1, 0, 0, 1, 0);   // enter edit one, section from unit one
        push_scan(0, 1, 0, 0, 0, 1);
        push_scan(0, 1, 0, 0, 1, 1);
        push_scan(1, 1, 0, 0, 0, 0);   // both keys expire together
        push_scan(1, 0, 0, 0, 1, 0);
        push_scan(1, 0, 0, 0, 0, 1);   // step down to step zero
        push_scan(0, 0, 0, 0, 0, 0);
        push_scan(1, 0, 0, 1, 0, 1);   // section request on unit two
        push_scan(0, 1, 1, 0, 1, 0);   // section request on unit one
        push_scan(0, 1, 1, 1, 0, 0);   // both view buttons: section request on unit one
        push_scan(0, 0, 1, 1, 1, 1);
        push_scan(1, 1, 0, 0, 0, 1);
        push_scan(1, 1, 1, 1, 1, 1);
        push_scan(0, 0, 0, 0, 0, 0);
        wait_drained();

        for (int p = 0; p < 8; p++) begin
            // idle mix: sender light/receiver heavy, then swapped, then none
            if (p < 3) begin
                send_idle_pct = 22;
                recv_idle_pct = 81;
            end else if (p < 6) begin
                send_idle_pct = 81;
                recv_idle_pct = 22;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (p)
                0: ;
                1: program_all(0, 1, 0, 0, 0);
                2: program_all(7, 0, 3, 2, 5);
                3: program_all($urandom_range(31), $urandom_range(1), $urandom_range(6),
                               $urandom_range(6), $urandom_range(6));
                4: program_all(31, 0, 65535, 65535, 65535);
                5: program_all(1, 0, 2, 1, 1);
                6: program_all($urandom_range(31), $urandom_range(1), $urandom_range(8),
                               $urandom_range(4), $urandom_range(8));
                default: program_all(15, 0, 4, 3, 8);
            endcase
            queue_key_play((p == 4) ? 60 : 178);
            wait_drained();
        end

        repeat (10) @(posedge aclk);
        if (expected_results.size() != 0) begin
            $error("%0d predicted results never arrived", expected_results.size());
            fault_cnt++;
        end
        if (fault_cnt == 0) begin
            $display("[panel_step_navigation_autorepeat] OK");
        end else begin
            $display("[panel_step_navigation_autorepeat] ERROR");
        end
        $finish;
    end

    // Hard stop well past the slowest correct run
    initial begin
        #2000000;
        $display("[panel_step_navigation_autorepeat] ERROR");
        $finish;
    end
endmodule
